// ----- hdl/pi_position_controller_top_defines.svh -----
// Assertion macros for the PI position controller RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef PI_POSITION_CONTROLLER_TOP_DEFINES_SVH
`define PI_POSITION_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PIPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PIPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIPC_ASSERT(lbl, clk, rst, prop, msg)
`define PIPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/pipc_pkg.sv -----
// Shared widths, register indexes, reset values and structs of the PI position controller.
// Has no dependencies; pipc_div5, pipc_update, the top level and the testbench import it.
package pipc_pkg;

   localparam int PosW       = 24;
   localparam int ErrW       = 25;
   localparam int MagW       = 24;
   localparam int QMagW      = 22;
   localparam int QuotW      = 23;
   localparam int IntW       = 17;
   localparam int DrvW       = 26;
   localparam int CfgW       = 16;
   localparam int CsrIdxW    = 2;
   localparam int ReqDataW   = 48;
   localparam int RspDataW   = 32;
   localparam int RecipShift = 26;

   localparam logic [MagW-1:0] RECIP5 = 24'd13421773;

   localparam logic [CsrIdxW-1:0] REG_DEADBAND   = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_INT_LIMIT  = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_SLEW_LIMIT = 2'd2;

   localparam logic [CfgW-1:0] DEADBAND_RST   = 16'd0;
   localparam logic [CfgW-1:0] INT_LIMIT_RST  = 16'd400;
   localparam logic [CfgW-1:0] SLEW_LIMIT_RST = 16'd100;

   typedef struct packed {
      logic [CfgW-1:0] deadband;
      logic [CfgW-1:0] integral_limit;
      logic [CfgW-1:0] slew_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [ErrW-1:0]  err;
      logic [MagW-1:0]         mag;
      logic signed [QuotW-1:0] quot;
      logic                    rem_nz;
   } div_type;

endpackage

// ----- hdl/pipc_div5.sv -----
// Position error and its truncated quotient by five (reciprocal multiply).
// Depends on pipc_pkg.
module pipc_div5 (
   input  logic signed [pipc_pkg::PosW-1:0] measured_pos,
   input  logic signed [pipc_pkg::PosW-1:0] target_pos,
   output pipc_pkg::div_type                div_o
);
   import pipc_pkg::*;

   logic signed [ErrW-1:0]  err;
   logic [MagW-1:0]         mag;
   logic [2*MagW-1:0]       prod;
   logic [QMagW-1:0]        q_mag;
   logic [MagW-1:0]         back;
   logic signed [QuotW-1:0] q_pos;

   assign err   = ErrW'(measured_pos) - ErrW'(target_pos);
   assign mag   = err[ErrW-1] ? MagW'(-err) : MagW'(err);
   assign prod  = mag * RECIP5;
   assign q_mag = prod[RecipShift +: QMagW];
   assign back  = MagW'({q_mag, 2'b00}) + MagW'(q_mag);
   assign q_pos = $signed({1'b0, q_mag});

   assign div_o.err    = err;
   assign div_o.mag    = mag;
   assign div_o.quot   = err[ErrW-1] ? -q_pos : q_pos;
   assign div_o.rem_nz = (mag != back);

endmodule

// ----- hdl/pipc_update.sv -----
// Integral and previous-drive state with the PI, clamp, slew and deadband update.
// Depends on pipc_pkg and the assertion macro header.
`include "pi_position_controller_top_defines.svh"

module pipc_update (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  pipc_pkg::cfg_type                cfg,
   input  pipc_pkg::div_type                div_i,
   input  logic                             clear_integral,
   output logic signed [pipc_pkg::DrvW-1:0] drive_o,
   output logic                             dead_o
);
   import pipc_pkg::*;

   localparam int TW = 24;
   localparam int SW = DrvW + 1;

   logic signed [IntW-1:0] integral_ff, integral_in;
   logic signed [DrvW-1:0] last_drive_ff, last_drive_in;
   logic signed [IntW-1:0] i0;
   logic signed [TW-1:0]   t, t_adj, ilim;
   logic signed [IntW-1:0] int_clamp;
   logic signed [DrvW-1:0] sum;
   logic signed [SW-1:0]   sum_w, hi, lo, slew, drv_w;
   logic signed [DrvW-1:0] drv;
   logic                   t_pos, t_neg, err_neg, dead;
   logic [IntW-1:0]        int_mag;

   assign i0      = clear_integral ? '0 : integral_ff;
   assign t       = TW'(i0) + TW'(div_i.quot);
   assign t_neg   = t[TW-1];
   assign t_pos   = !t[TW-1] && (t != '0);
   assign err_neg = div_i.err[ErrW-1];
   assign ilim    = TW'($signed({1'b0, cfg.integral_limit}));

   always_comb begin
      priority if (div_i.rem_nz && t_pos && err_neg) begin
         t_adj = t - TW'(1);
      end else if (div_i.rem_nz && t_neg && !err_neg) begin
         t_adj = t + TW'(1);
      end else begin
         t_adj = t;
      end
   end

   always_comb begin
      priority if (t_adj > ilim) begin
         int_clamp = IntW'(ilim);
      end else if (t_adj < -ilim) begin
         int_clamp = IntW'(-ilim);
      end else begin
         int_clamp = IntW'(t_adj);
      end
   end

   assign sum   = DrvW'(div_i.err) + DrvW'(int_clamp);
   assign sum_w = SW'(sum);
   assign slew  = SW'($signed({1'b0, cfg.slew_limit}));
   assign hi    = SW'(last_drive_ff) + slew;
   assign lo    = SW'(last_drive_ff) - slew;

   always_comb begin
      priority if (sum_w > hi) begin
         drv_w = hi;
      end else if (sum_w < lo) begin
         drv_w = lo;
      end else begin
         drv_w = sum_w;
      end
   end

   assign drv  = DrvW'(drv_w);
   assign dead = div_i.mag < MagW'(cfg.deadband);

   assign integral_in   = dead ? '0 : int_clamp;
   assign last_drive_in = drv;
   assign drive_o       = dead ? '0 : -drv;
   assign dead_o        = dead;

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         last_drive_ff <= '0;
      end else if (fire) begin
         integral_ff   <= integral_in;
         last_drive_ff <= last_drive_in;
      end
   end

   assign int_mag = integral_ff[IntW-1] ? IntW'(-integral_ff) : IntW'(integral_ff);

   `PIPC_ASSERT(a_state_hold, clock, reset, !fire |=> $stable(integral_ff) && $stable(last_drive_ff), "state changed without a transfer")
   `PIPC_ASSERT(a_dead_clears, clock, reset, fire && dead |=> integral_ff == '0, "integral not cleared in deadband")
   `PIPC_ASSERT(a_int_bound, clock, reset, $past(fire) |-> int_mag <= IntW'($past(cfg.integral_limit)), "integral beyond its limit")

endmodule

// ----- hdl/pi_position_controller_top.sv -----
// Top level of the PI position controller: stream pipeline, register port, output register.
// Depends on pipc_pkg, pipc_div5, pipc_update and the assertion macro header.
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    tdata: measured_pos, target_pos; tuser: clear
//   rsp_      out        rsp_tvalid/tready    tdata: drive; tuser: in_deadband
//   csr_      in         csr_we               csr_index, csr_wdata
//
// One item per cycle sustained while the output is not stalled; a result passes through the
// input, divide-by-five and result registers before it leaves.
// The integral and previous-drive feedback closes within the last stage.
// Each stage advances when the one after it is empty or moving, so bubbles fill under stall.
// Synchronous reset empties the pipeline, zeroes the state and loads register defaults.
`include "pi_position_controller_top_defines.svh"

module pi_position_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pipc_pkg::ReqDataW-1:0]       req_tdata,   // measured_pos, target_pos
   input  logic                                req_tuser,   // clear_integral
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pipc_pkg::RspDataW-1:0]       rsp_tdata,   // drive, zero pad
   output logic                                rsp_tuser,   // in_deadband
   input  logic                                csr_we,
   input  logic [pipc_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [pipc_pkg::CfgW-1:0]           csr_wdata
);
   import pipc_pkg::*;

   cfg_type                cfg_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic signed [PosW-1:0] s1_meas_ff, s1_tgt_ff;
   logic                   s1_clr_ff;
   logic                   s2_valid_ff, s2_valid_in;
   div_type                s2_div_ff;
   logic                   s2_clr_ff;
   logic                   out_valid_ff, out_valid_in;
   logic signed [DrvW-1:0] out_drive_ff;
   logic                   out_dead_ff;
   div_type                div;
   logic signed [DrvW-1:0] drive;
   logic                   dead;
   logic                   ready_out, ready2, ready1, fire2;

   assign ready_out = !out_valid_ff || rsp_tready;
   assign ready2    = !s2_valid_ff || ready_out;
   assign ready1    = !s1_valid_ff || ready2;
   assign fire2     = s2_valid_ff && ready_out;
   assign req_tready = ready1;

   assign s1_valid_in  = ready1 ? req_tvalid : s1_valid_ff;
   assign s2_valid_in  = ready2 ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = ready_out ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband       <= DEADBAND_RST;
         cfg_ff.integral_limit <= INT_LIMIT_RST;
         cfg_ff.slew_limit     <= SLEW_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEADBAND:   cfg_ff.deadband       <= csr_wdata;
            REG_INT_LIMIT:  cfg_ff.integral_limit <= csr_wdata;
            REG_SLEW_LIMIT: cfg_ff.slew_limit     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && ready1) begin
         s1_meas_ff <= $signed(req_tdata[PosW-1:0]);
         s1_tgt_ff  <= $signed(req_tdata[2*PosW-1:PosW]);
         s1_clr_ff  <= req_tuser;
      end
      if (s1_valid_ff && ready2) begin
         s2_div_ff <= div;
         s2_clr_ff <= s1_clr_ff;
      end
      if (fire2) begin
         out_drive_ff <= drive;
         out_dead_ff  <= dead;
      end
   end

   pipc_div5 u_div5 (
      .measured_pos (s1_meas_ff),
      .target_pos   (s1_tgt_ff),
      .div_o        (div)
   );

   pipc_update u_update (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire2),
      .cfg            (cfg_ff),
      .div_i          (s2_div_ff),
      .clear_integral (s2_clr_ff),
      .drive_o        (drive),
      .dead_o         (dead)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW-DrvW){1'b0}}, out_drive_ff};
   assign rsp_tuser  = out_dead_ff;

   `PIPC_ASSERT(a_dead_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[DrvW-1:0] == '0, "nonzero drive in deadband")
   `PIPC_ASSERT(a_full_stall, clock, reset, s1_valid_ff && s2_valid_ff && !ready_out |-> !req_tready, "transfer taken into a full stalled pipeline")

endmodule

// ----- tb/tb_pi_position_controller_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pi_position_controller_top: stream transfers in and out,
// register writes between phases, and a scoreboard class that predicts each drive result.
// Depends on pipc_pkg and the RTL of the PI position controller.
module tb_pi_position_controller_top;
   import pipc_pkg::*;

   localparam logic [CsrIdxW-1:0] REG_UNUSED = 2'd3;
   localparam logic signed [PosW-1:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [PosW-1:0] POS_MIN = 24'sh800000;
   localparam int SEGMENTS = 6;
   localparam int TICKS_PER_SEGMENT = 142;

   class drive_scoreboard;
      typedef struct {
         logic signed [DrvW-1:0] drive;
         logic                   in_deadband;
      } drive_result_t;

      logic [CfgW-1:0]        deadband;
      logic [CfgW-1:0]        integral_limit;
      logic [CfgW-1:0]        slew_limit;
      logic signed [IntW-1:0] integral;
      logic signed [DrvW-1:0] last_drive;
      drive_result_t          expected_drives[$];
      int                     errors;
      int                     results_seen;

      function new();
         deadband       = DEADBAND_RST;
         integral_limit = INT_LIMIT_RST;
         slew_limit     = SLEW_LIMIT_RST;
         integral       = '0;
         last_drive     = '0;
         errors         = 0;
         results_seen   = 0;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [CfgW-1:0] val);
         case (idx)
            REG_DEADBAND:   deadband = val;
            REG_INT_LIMIT:  integral_limit = val;
            REG_SLEW_LIMIT: slew_limit = val;
            default: ;
         endcase
      endfunction

      function void note_tick(logic signed [PosW-1:0] meas, logic signed [PosW-1:0] tgt,
                              logic clr);
         longint err, integ, ilim, lo, hi, drv, mag;
         logic dead;
         drive_result_t r;
         integ = clr ? 0 : longint'(integral);
         err   = longint'(meas) - longint'(tgt);
         integ = (5 * integ + err) / 5;
         ilim  = longint'(integral_limit);
         if (integ > ilim) integ = ilim;
         if (integ < -ilim) integ = -ilim;
         lo  = longint'(last_drive) - longint'(slew_limit);
         hi  = longint'(last_drive) + longint'(slew_limit);
         drv = err + integ;
         if (drv > hi) drv = hi;
         if (drv < lo) drv = lo;
         last_drive = DrvW'(drv);
         mag  = err < 0 ? -err : err;
         dead = mag < longint'(deadband);
         if (dead) begin
            drv   = 0;
            integ = 0;
         end
         integral      = IntW'(integ);
         r.drive       = DrvW'(-drv);
         r.in_deadband = dead;
         expected_drives.push_back(r);
      endfunction

      function void check_result(logic [RspDataW-1:0] data, logic user);
         drive_result_t r;
         results_seen++;
         if (expected_drives.size() == 0) begin
            $error("unexpected result: drive %0d in_deadband %0b",
                   $signed(data[DrvW-1:0]), user);
            errors++;
            return;
         end
         r = expected_drives.pop_front();
         if (data[DrvW-1:0] !== r.drive) begin
            $error("drive: expected %0d, actual %0d", r.drive, $signed(data[DrvW-1:0]));
            errors++;
         end
         if (user !== r.in_deadband) begin
            $error("in_deadband: expected %0b, actual %0b", r.in_deadband, user);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqDataW-1:0]  req_tdata = '0;   // measured_pos, target_pos
   logic                 req_tuser = 1'b0; // clear_integral
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RspDataW-1:0]  rsp_tdata;        // drive, zero pad
   logic                 rsp_tuser;        // in_deadband
   logic                 csr_we = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [CfgW-1:0]      csr_wdata = '0;

   drive_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int ticks_sent = 0;
   logic signed [PosW-1:0] run_target = '0;

   pi_position_controller_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_tick(req_tdata[PosW-1:0], req_tdata[2*PosW-1:PosW], req_tuser);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_tick(input logic signed [PosW-1:0] meas,
                            input logic signed [PosW-1:0] tgt, input logic clr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tgt, meas};
      req_tuser  <= clr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // hold off new transfers until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.results_seen < ticks_sent) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CfgW-1:0] db, input logic [CfgW-1:0] il,
                               input logic [CfgW-1:0] sl);
      logic [CsrIdxW-1:0] idx[4];
      logic [CfgW-1:0]    vals[4];
      idx  = '{REG_DEADBAND, REG_INT_LIMIT, REG_SLEW_LIMIT, REG_UNUSED};
      vals = '{db, il, sl, CfgW'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         board.set_reg(idx[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_tick();
      int span;
      int delta;
      int pick;
      logic signed [PosW-1:0] meas;
      if ($urandom_range(99) < 5) run_target = PosW'($urandom);
      pick = $urandom_range(9);
      if (pick < 6) span = int'(board.deadband) + 20;
      else span = 5000;
      delta = int'($urandom_range(2 * span)) - span;
      meas  = run_target + PosW'(delta);
      if (pick == 9) meas = PosW'($urandom);
      send_tick(meas, run_target, $urandom_range(99) < 8);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 81;

      // reset defaults
      send_tick('0, '0, 1'b0);
      send_tick(POS_MAX, POS_MIN, 1'b0);
      send_tick(POS_MIN, POS_MAX, 1'b0);
      send_tick(24'sd100, '0, 1'b1);
      send_tick(-24'sd1, '0, 1'b0);
      send_tick('0, -24'sd1, 1'b0);
      drain();

      // zero limits: integral pinned, drive held
      program_regs('0, '0, '0);
      send_tick(POS_MAX, POS_MIN, 1'b0);
      send_tick(24'sd5000, '0, 1'b0);
      send_tick(POS_MIN, '0, 1'b1);
      drain();

      program_regs('1, '1, '1);
      send_tick(POS_MAX, POS_MIN, 1'b0);
      send_tick(POS_MIN, POS_MAX, 1'b0);
      send_tick(24'sd65535, '0, 1'b0);
      send_tick(24'sd65534, '0, 1'b0);
      send_tick('0, 24'sd65534, 1'b0);
      send_tick(POS_MAX, '0, 1'b1);
      drain();

      program_regs(16'd1000, 16'd400, 16'd100);
      send_tick('0, '0, 1'b0);
      send_tick(24'sd999, '0, 1'b0);
      send_tick(24'sd1000, '0, 1'b0);
      send_tick('0, 24'sd1000, 1'b0);
      send_tick(-24'sd999, '0, 1'b1);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         if (seg < 2) begin
            send_idle_pct = 27;
            recv_idle_pct = 81;
         end else if (seg < 4) begin
            send_idle_pct = 81;
            recv_idle_pct = 27;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (seg)
            1: program_regs('1, '1, '1);
            3: program_regs('0, '0, '0);
            default: program_regs(CfgW'($urandom_range(300)), CfgW'($urandom_range(2000)),
                                  CfgW'($urandom_range(5000)));
         endcase
         for (int n = 0; n < TICKS_PER_SEGMENT; n++) random_tick();
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.expected_drives.size() != 0) begin
         $error("%0d expected results never arrived", board.expected_drives.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("pi_position_controller_top test passed");
      end else begin
         $display("pi_position_controller_top test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("pi_position_controller_top test failed");
      $finish;
   end

endmodule
